// ===== rtl/ssta_pkg.sv =====
// shared types, constants and helper functions of the symmetric tensor accumulator
// no dependencies
package ssta_pkg;

    localparam int NUM_COMP = 46;
    localparam int IDX_W    = 6;
    localparam int ACC_W    = 48;
    localparam int OUT_W    = 48;
    localparam int SUM_W    = ((ACC_W > OUT_W) ? ACC_W : OUT_W) + 1;
    localparam int EW       = 16;
    localparam int PW       = 32;
    localparam int XW       = 48;
    localparam int XL_W     = 24;
    localparam int TW       = 82;
    localparam int MW       = 80;
    localparam int DIGIT_W  = 8;
    localparam int DIV_STAGES = MW / DIGIT_W;
    localparam int SHIFT    = 33;
    localparam int DW       = MW - SHIFT + 1;
    localparam int N_LANE   = 9;
    localparam int SB_LEN   = 4 + 3 + DIV_STAGES;
    localparam logic [12:0] RECIP9 = 13'd7282;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [47:0] k_row0;
        logic [47:0] k_row1;
        logic [47:0] k_row2;
        logic [47:0] vec_a;
        logic [47:0] vec_b;
        logic        clear_sum;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        component_index;
        logic signed [OUT_W-1:0] component_sum;
        logic                    last_component;
    } t_out_item;

    typedef struct packed {
        logic signed [PW-1:0] aa1;
        logic signed [EW-1:0] k1;
        logic signed [PW-1:0] bb1;
        logic signed [PW-1:0] aa2;
        logic signed [EW-1:0] k2;
        logic signed [PW-1:0] bb2;
    } t_lane_op;

    typedef logic [0:5][1:0] t_tuple;

    localparam t_tuple TUPLE [NUM_COMP] = '{
        12'b00_00_00_00_00_00, 12'b00_00_00_00_00_01, 12'b00_00_00_00_00_10,
        12'b00_00_00_00_01_01, 12'b00_00_00_00_01_10, 12'b00_00_00_00_10_10,
        12'b00_00_00_01_01_01, 12'b00_00_00_01_01_10, 12'b00_00_00_01_10_10,
        12'b00_00_00_10_10_10, 12'b00_00_01_00_01_01, 12'b00_00_01_00_01_10,
        12'b00_00_01_00_10_10, 12'b00_00_01_01_01_01, 12'b00_00_01_01_01_10,
        12'b00_00_01_01_10_10, 12'b00_00_01_10_10_10, 12'b00_00_10_00_01_01,
        12'b00_00_10_00_01_10, 12'b00_00_10_00_10_10, 12'b00_00_10_01_01_01,
        12'b00_00_10_01_01_10, 12'b00_00_10_01_10_10, 12'b00_00_10_10_10_10,
        12'b00_01_01_00_10_10, 12'b00_01_01_01_01_01, 12'b00_01_01_01_01_10,
        12'b00_01_01_01_10_10, 12'b00_01_01_10_10_10, 12'b00_01_10_00_10_10,
        12'b00_01_10_01_01_01, 12'b00_01_10_01_01_10, 12'b00_01_10_01_10_10,
        12'b00_01_10_10_10_10, 12'b00_10_10_01_01_01, 12'b00_10_10_01_01_10,
        12'b00_10_10_01_10_10, 12'b00_10_10_10_10_10, 12'b01_01_01_01_01_01,
        12'b01_01_01_01_01_10, 12'b01_01_01_01_10_10, 12'b01_01_01_10_10_10,
        12'b01_01_10_01_10_10, 12'b01_01_10_10_10_10, 12'b01_10_10_10_10_10,
        12'b10_10_10_10_10_10
    };

    // slot of the product of elements x and y among the six distinct pairs
    function automatic logic [2:0] pair_idx(input logic [1:0] x, input logic [1:0] y);
        logic [1:0] lo;
        logic [1:0] hi;
        logic [2:0] r;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        case ({lo, hi})
            4'b0000: r = 3'd0;
            4'b0001: r = 3'd1;
            4'b0010: r = 3'd2;
            4'b0101: r = 3'd3;
            4'b0110: r = 3'd4;
            4'b1010: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [EW-1:0] elem(input logic [47:0] f, input int e);
        return $signed(f[EW*e +: EW]);
    endfunction

endpackage

// ===== rtl/sym_sixth_order_tensor_accum.sv =====
// symmetric sixth-order tensor accumulator, top level
// results leave one per cycle while the receiver does not stall; a new item is taken only
// once all 46 results of the previous one have been issued and have drained from the pipeline
// reset (synchronous, active low) clears all 46 sums and the control state
// depends on ssta_pkg, ssta_lane, ssta_merge, ssta_div9
module sym_sixth_order_tensor_accum
    import ssta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_cnt, n_cnt;
    logic signed [PW-1:0]   r_aa [6];
    logic signed [PW-1:0]   r_bb [6];
    logic signed [EW-1:0]   r_k  [9];
    logic                   en, accept, issue;

    t_lane_op               lane_op  [N_LANE];
    logic signed [TW-1:0]   lane_sum [N_LANE];
    logic [MW-1:0]          mag, quo;
    logic                   mag_neg, quo_neg;

    logic                   r_sb_vld [SB_LEN];
    logic [IDX_W-1:0]       r_sb_idx [SB_LEN];

    logic signed [DW-1:0]   r_d;
    logic                   r_d_vld;
    logic [IDX_W-1:0]       r_d_idx;
    logic [ACC_W-1:0]       r_rd;
    logic                   r_rdv;
    logic [ACC_W-1:0]       r_mem [NUM_COMP];
    logic [NUM_COMP-1:0]    r_vld;

    logic                   r_out_vld;
    t_out_item              r_out;

    logic [DW-1:0]          n_qs;
    logic signed [DW-1:0]   n_d;
    logic signed [ACC_W-1:0] n_acc_old, n_acc;
    logic signed [SUM_W-1:0] n_sum;

    assign en     = !(r_out_vld && i_out_stall);
    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign issue  = (r_state == ST_ISSUE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ISSUE;
                    n_cnt   = '0;
                end
            end
            ST_ISSUE: begin
                if (en) begin
                    n_cnt = r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(NUM_COMP - 1)) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (r_out_vld && !i_out_stall && r_out.last_component) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // pair products of the vectors, and the matrix elements, captured with the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int x = 0; x < 3; x++) begin
                for (int y = x; y < 3; y++) begin
                    r_aa[pair_idx(2'(x), 2'(y))] <=
                        elem(i_in_data.vec_a, x) * elem(i_in_data.vec_a, y);
                    r_bb[pair_idx(2'(x), 2'(y))] <=
                        elem(i_in_data.vec_b, x) * elem(i_in_data.vec_b, y);
                end
                r_k[x]     <= elem(i_in_data.k_row0, x);
                r_k[3 + x] <= elem(i_in_data.k_row1, x);
                r_k[6 + x] <= elem(i_in_data.k_row2, x);
            end
        end
    end

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gu = 0; gu < 3; gu++) begin : g_col
            t_tuple     tp;
            logic [2:0] pi, pl;
            logic [3:0] kil, kli;

            assign tp  = TUPLE[r_cnt];
            assign pi  = pair_idx(tp[(gr + 1) % 3], tp[(gr + 2) % 3]);
            assign pl  = pair_idx(tp[3 + (gu + 1) % 3], tp[3 + (gu + 2) % 3]);
            assign kil = 4'(tp[gr]) * 4'd3 + 4'(tp[3 + gu]);
            assign kli = 4'(tp[3 + gu]) * 4'd3 + 4'(tp[gr]);

            always_comb begin
                lane_op[3*gr+gu].aa1 = r_aa[pi];
                lane_op[3*gr+gu].k1  = r_k[kil];
                lane_op[3*gr+gu].bb1 = r_bb[pl];
                lane_op[3*gr+gu].aa2 = r_aa[pl];
                lane_op[3*gr+gu].k2  = r_k[kli];
                lane_op[3*gr+gu].bb2 = r_bb[pi];
            end

            ssta_lane u_lane (
                .i_clk (i_clk),
                .i_en  (en),
                .i_op  (lane_op[3*gr+gu]),
                .o_sum (lane_sum[3*gr+gu])
            );
        end
    end

    ssta_merge u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sum (lane_sum),
        .o_mag (mag),
        .o_neg (mag_neg)
    );

    ssta_div9 u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (mag),
        .i_neg (mag_neg),
        .o_quo (quo),
        .o_neg (quo_neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SB_LEN; s++) begin
                r_sb_vld[s] <= 1'b0;
            end
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_sb_vld[0] <= issue;
            for (int s = 1; s < SB_LEN; s++) begin
                r_sb_vld[s] <= r_sb_vld[s-1];
            end
            r_d_vld <= r_sb_vld[SB_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_idx[0] <= r_cnt;
            for (int s = 1; s < SB_LEN; s++) begin
                r_sb_idx[s] <= r_sb_idx[s-1];
            end
        end
    end

    // floor of the truncated quotient over 2^33
    assign n_qs = {1'b0, quo[MW-1:SHIFT]};
    assign n_d  = quo_neg ? -$signed(n_qs + DW'(|quo[SHIFT-1:0])) : $signed(n_qs);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d     <= n_d;
            r_d_idx <= r_sb_idx[SB_LEN-1];
            r_rd    <= r_mem[r_sb_idx[SB_LEN-1]];
            r_rdv   <= r_vld[r_sb_idx[SB_LEN-1]];
        end
    end

    assign n_acc_old = r_rdv ? $signed(r_rd) : '0;
    assign n_sum     = SUM_W'(n_acc_old) + SUM_W'(r_d);

    always_comb begin
        if (n_sum > SUM_W'(ACC_MAX)) begin
            n_acc = ACC_MAX;
        end else if (n_sum < SUM_W'(ACC_MIN)) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = ACC_W'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept && i_in_data.clear_sum) begin
                r_vld <= '0;
            end else if (en && r_d_vld) begin
                r_vld[r_d_idx] <= 1'b1;
            end
            if (en) begin
                r_out_vld <= r_d_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_d_vld) begin
            r_mem[r_d_idx]        <= n_acc;
            r_out.component_index <= r_d_idx;
            r_out.component_sum   <= OUT_W'(n_acc);
            r_out.last_component  <= (r_d_idx == IDX_W'(NUM_COMP - 1));
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/ssta_lane.sv =====
// one lane: the two five-factor products of one index pair, summed
// depends on ssta_pkg
module ssta_lane
    import ssta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_lane_op             i_op,
    output logic signed [TW-1:0] o_sum
);

    logic signed [XW-1:0]        r_x1, r_x2;
    logic signed [PW-1:0]        r_b1, r_b2;
    logic signed [XL_W+PW-1:0]   r_h1, r_h2;
    logic signed [XL_W+PW:0]     r_l1, r_l2;
    logic signed [TW-1:0]        r_t1, r_t2;
    logic signed [TW-1:0]        r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1  <= i_op.aa1 * i_op.k1;
            r_x2  <= i_op.aa2 * i_op.k2;
            r_b1  <= i_op.bb1;
            r_b2  <= i_op.bb2;
            r_h1  <= $signed(r_x1[XW-1:XL_W]) * r_b1;
            r_l1  <= $signed({1'b0, r_x1[XL_W-1:0]}) * r_b1;
            r_h2  <= $signed(r_x2[XW-1:XL_W]) * r_b2;
            r_l2  <= $signed({1'b0, r_x2[XL_W-1:0]}) * r_b2;
            r_t1  <= (TW'(r_h1) <<< XL_W) + TW'(r_l1);
            r_t2  <= (TW'(r_h2) <<< XL_W) + TW'(r_l2);
            r_sum <= r_t1 + r_t2;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/ssta_merge.sv =====
// registered adder tree over the lane sums, then sign and halved magnitude
// depends on ssta_pkg
module ssta_merge
    import ssta_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [TW-1:0] i_sum [N_LANE],
    output logic [MW-1:0]        o_mag,
    output logic                 o_neg
);

    logic signed [TW-1:0] r_grp [3];
    logic signed [TW-1:0] r_tot;
    logic [MW-1:0]        r_mag;
    logic                 r_neg;
    logic [TW-1:0]        n_abs;

    assign n_abs = r_tot[TW-1] ? -r_tot : r_tot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < 3; g++) begin
                r_grp[g] <= i_sum[3*g] + i_sum[3*g+1] + i_sum[3*g+2];
            end
            r_tot <= r_grp[0] + r_grp[1] + r_grp[2];
            r_mag <= n_abs[MW:1];
            r_neg <= r_tot[TW-1];
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

// ===== rtl/ssta_div9.sv =====
// pipelined division by nine, one byte of the dividend per stage
// depends on ssta_pkg
module ssta_div9
    import ssta_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_mag,
    input  logic          i_neg,
    output logic [MW-1:0] o_quo,
    output logic          o_neg
);

    logic [MW-1:0] w_m   [DIV_STAGES+1];
    logic [MW-1:0] w_q   [DIV_STAGES+1];
    logic [3:0]    w_rem [DIV_STAGES+1];
    logic          w_neg [DIV_STAGES+1];

    assign w_m[0]   = i_mag;
    assign w_q[0]   = '0;
    assign w_rem[0] = '0;
    assign w_neg[0] = i_neg;

    for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
        logic [11:0]          n_cur;
        logic [24:0]          n_prod;
        logic [DIGIT_W-1:0]   n_qd;
        logic [11:0]          n_rem;
        logic [MW-1:0]        r_m, r_q;
        logic [3:0]           r_rem;
        logic                 r_neg;

        assign n_cur  = {w_rem[gs], w_m[gs][MW-1 -: DIGIT_W]};
        assign n_prod = 25'(n_cur) * 25'(RECIP9);
        assign n_qd   = n_prod[23:16];
        assign n_rem  = n_cur - 12'(n_qd) * 12'd9;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m   <= w_m[gs] << DIGIT_W;
                r_q   <= {w_q[gs][MW-DIGIT_W-1:0], n_qd};
                r_rem <= n_rem[3:0];
                r_neg <= w_neg[gs];
            end
        end

        assign w_m[gs+1]   = r_m;
        assign w_q[gs+1]   = r_q;
        assign w_rem[gs+1] = r_rem;
        assign w_neg[gs+1] = r_neg;
    end

    assign o_quo = w_q[DIV_STAGES];
    assign o_neg = w_neg[DIV_STAGES];

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for sym_sixth_order_tensor_accum
// predicts all 46 accumulated components per item with exact wide arithmetic
// depends on ssta_pkg and the block's rtl
module tb_top;
    import ssta_pkg::*;

    localparam int LIMIT = 600000;
    localparam int PERM [6][3] = '{'{0,1,2}, '{0,2,1}, '{1,0,2}, '{1,2,0}, '{2,0,1}, '{2,1,0}};

    class tensor_scoreboard;
        logic signed [ACC_W-1:0] sums [NUM_COMP];
        t_out_item expected_q [$];
        int errors;
        int checked;

        function new();
            foreach (sums[c]) sums[c] = '0;
            errors = 0;
            checked = 0;
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endtask

        function automatic logic signed [95:0] el(logic [47:0] f, int e);
            logic signed [15:0] v;
            v = f[16*e +: 16];
            return v;
        endfunction

        function void note_input(t_in_item it);
            logic signed [95:0] k [3][3];
            logic signed [95:0] a [3];
            logic signed [95:0] b [3];
            logic signed [95:0] s;
            logic signed [95:0] nxt;
            logic signed [95:0] maxv;
            logic signed [95:0] minv;
            logic [47:0] rows [3];
            int p, q, r, u, v, w;
            t_tuple tp;
            t_out_item o;
            maxv = (96'sd1 <<< (ACC_W - 1)) - 96'sd1;
            minv = -maxv - 96'sd1;
            rows[0] = it.k_row0;
            rows[1] = it.k_row1;
            rows[2] = it.k_row2;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) k[i][j] = el(rows[i], j);
                a[i] = el(it.vec_a, i);
                b[i] = el(it.vec_b, i);
            end
            if (it.clear_sum) foreach (sums[c]) sums[c] = '0;
            for (int c = 0; c < NUM_COMP; c++) begin
                tp = TUPLE[c];
                s = '0;
                for (int x = 0; x < 6; x++) begin
                    p = tp[PERM[x][0]];
                    q = tp[PERM[x][1]];
                    r = tp[PERM[x][2]];
                    for (int y = 0; y < 6; y++) begin
                        u = tp[3 + PERM[y][0]];
                        v = tp[3 + PERM[y][1]];
                        w = tp[3 + PERM[y][2]];
                        s = s + a[p] * a[q] * k[r][u] * b[v] * b[w];
                        s = s + a[u] * a[v] * k[w][p] * b[q] * b[r];
                    end
                end
                // truncating divide, then floor shift that drops 33 fraction bits
                s = s / 96'sd72;
                s = s >>> 33;
                nxt = sums[c];
                nxt = nxt + s;
                if (nxt > maxv) nxt = maxv;
                else if (nxt < minv) nxt = minv;
                sums[c] = nxt[ACC_W-1:0];
                o.component_index = c[IDX_W-1:0];
                o.component_sum = nxt[OUT_W-1:0];
                o.last_component = (c == NUM_COMP - 1);
                expected_q.push_back(o);
            end
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report("unexpected item, index", got.component_index, -1);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.component_index !== want.component_index)
                report("component_index", got.component_index, want.component_index);
            if (got.component_sum !== want.component_sum)
                report($sformatf("component_sum[%0d]", want.component_index),
                       got.component_sum, want.component_sum);
            if (got.last_component !== want.last_component)
                report("last_component", got.last_component, want.last_component);
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    tensor_scoreboard sb;
    int cycles;
    int items_sent;
    int clears_sent;
    int stall_mode;
    int stall_left;

    sym_sixth_order_tensor_accum uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        sb = new();
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sym_sixth_order_tensor_accum verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // receiver stall pattern: quiet stretches, random stalls, periodic stall bursts
    initial begin
        i_out_stall = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0: i_out_stall = 1'b0;
                1: i_out_stall = ($urandom_range(0, 3) == 0);
                2: i_out_stall = ($urandom_range(0, 1) == 0);
                default: i_out_stall = ((stall_left % 16) < 5);
            endcase
        end
    end

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_triple();
        return {rand_elem(), rand_elem(), rand_elem()};
    endfunction

    function automatic t_in_item all_same(logic [15:0] e, logic clr);
        t_in_item it;
        it.k_row0 = {3{e}};
        it.k_row1 = {3{e}};
        it.k_row2 = {3{e}};
        it.vec_a = {3{e}};
        it.vec_b = {3{e}};
        it.clear_sum = clr;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.k_row0 = rand_triple();
        it.k_row1 = rand_triple();
        it.k_row2 = rand_triple();
        it.vec_a = rand_triple();
        it.vec_b = rand_triple();
        it.clear_sum = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    task send_item(t_in_item it);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        items_sent++;
        if (it.clear_sum) clears_sent++;
    endtask

    task idle_gap(int n);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_in_data = rand_item();
        repeat (n) @(negedge i_clk);
    endtask

    task wait_drained();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task send_burst(int n);
        repeat (n) send_item(rand_item());
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 30));
    endtask

    initial begin
        t_in_item it;
        items_sent = 0;
        clears_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero, extremes, single elements, clear on and off
        send_item(all_same(16'h0000, 1'b0));
        send_item(all_same(16'h7FFF, 1'b0));
        send_item(all_same(16'h8000, 1'b0));
        send_item(all_same(16'hFFFF, 1'b1));
        send_item(all_same(16'h0001, 1'b0));
        for (int e = 0; e < 3; e++) begin
            it = all_same(16'h0000, 1'b0);
            it.vec_a[16*e +: 16] = 16'h8000;
            it.vec_b[16*e +: 16] = 16'h7FFF;
            it.k_row0[16*e +: 16] = 16'h8000;
            it.k_row1[16*e +: 16] = 16'h2000;
            it.k_row2[16*e +: 16] = 16'hE000;
            send_item(it);
        end
        it = all_same(16'h8000, 1'b1);
        it.vec_b = {3{16'h7FFF}};
        send_item(it);
        send_item(all_same(16'h7FFF, 1'b1));
        idle_gap(3);
        wait_drained();

        // drive sums into both saturation limits
        send_item(all_same(16'h8000, 1'b1));
        repeat (37) send_item(all_same(16'h8000, 1'b0));
        repeat (3) send_item(all_same(16'h7FFF, 1'b0));
        send_item(all_same(16'h7FFF, 1'b1));
        repeat (37) send_item(all_same(16'h7FFF, 1'b0));
        idle_gap($urandom_range(1, 10));

        while (items_sent < 250) begin
            send_burst($urandom_range(1, 12));
            if (items_sent > 200 && items_sent < 215) begin
                idle_gap(1);
                wait_drained();
            end
        end
        idle_gap(1);

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d items (%0d with clear_sum), checked %0d components",
                 items_sent, clears_sent, sb.checked);
        $display("covered element extremes, both saturation limits, random stalls and gaps");
        if (sb.errors == 0) begin
            $display("sym_sixth_order_tensor_accum verification clean");
        end else begin
            $display("sym_sixth_order_tensor_accum verification failed");
        end
        $finish;
    end
endmodule
